>>> rtl/core/shp_pkg.sv
// Shared types and constants for the 3x3 sharpen stream filter.
// Used by every module under rtl/core except shp_ram; depends on nothing else.
package shp_pkg;

	// Configuration port
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;
	localparam int IMG_W_BITS = 12;
	localparam int IMG_H_BITS = 16;

	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;

	localparam int RESET_WIDTH  = 640;
	localparam int RESET_HEIGHT = 480;

	// Input word kinds
	localparam logic OP_PIXEL = 1'b0;
	localparam logic OP_DRAIN = 1'b1;

	// Input row counter runs to height + 1 during the drain
	localparam int ROW_CNT_W = IMG_H_BITS + 1;

	// Job queue between the line stores and the output stage
	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	// Packed pixel as held in the line stores: R in the low byte
	typedef struct packed {
		logic [7:0] a;
		logic [7:0] b;
		logic [7:0] g;
		logic [7:0] r;
	} pixel_t;

	typedef struct packed {
		logic [7:0] b;
		logic [7:0] g;
		logic [7:0] r;
	} rgb_t;

	// Position class of an output pixel
	typedef struct packed {
		logic top;
		logic bottom;
		logic left_e;
		logic right_e;
		logic last;
	} cls_t;

	// One filled slot leaving the front end
	typedef struct packed {
		logic   emit;
		cls_t   cls;
		pixel_t data;
	} slot_t;

	// Full neighborhood of one output pixel
	typedef struct packed {
		pixel_t center;
		rgb_t   up;
		rgb_t   down;
		rgb_t   lft;
		rgb_t   rgt;
		cls_t   cls;
	} job_t;

	// Emitting slots still inside the line store pipeline
	typedef struct packed {
		logic s1_emit;
		logic s2_emit;
	} flight_t;

	typedef struct packed {
		logic       operation;
		logic [7:0] red_in;
		logic [7:0] green_in;
		logic [7:0] blue_in;
		logic [7:0] alpha_in;
	} in_item_t;

	typedef struct packed {
		logic [7:0] red_out;
		logic [7:0] green_out;
		logic [7:0] blue_out;
		logic [7:0] alpha_out;
		logic       frame_end;
	} out_item_t;

endpackage

>>> rtl/core/shp_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// Read returns the old contents on a same-address write. No dependencies.
module shp_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 2048
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

>>> rtl/core/shp_front.sv
// Front end: size registers, frame position counters and slot classification.
// Depends on shp_pkg.
module shp_front #(
	parameter int MAX_WIDTH = 2048
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [shp_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [shp_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  logic                            accept,
	input  shp_pkg::in_item_t               item,
	output logic                            slot_valid,
	output logic [$clog2(MAX_WIDTH)-1:0]    slot_col,
	output shp_pkg::slot_t                  slot
);

	localparam int CW    = $clog2(MAX_WIDTH);
	localparam int RST_W = (shp_pkg::RESET_WIDTH > MAX_WIDTH) ? MAX_WIDTH
	                                                          : shp_pkg::RESET_WIDTH;
	localparam logic [CW-1:0] RST_LAST_COL = CW'(RST_W - 1);
	localparam logic [shp_pkg::IMG_H_BITS-1:0] RST_LAST_ROW =
		shp_pkg::IMG_H_BITS'(shp_pkg::RESET_HEIGHT - 1);

	logic [CW-1:0]                     last_col_q;
	logic [shp_pkg::IMG_H_BITS-1:0]    last_row_q;
	logic [CW-1:0]                     in_col_q;
	logic [shp_pkg::ROW_CNT_W-1:0]     in_row_q;
	logic [CW-1:0]                     out_col_q;
	logic [shp_pkg::IMG_H_BITS-1:0]    out_row_q;

	logic [31:0]                       wr_w;
	logic [31:0]                       lastc_w;
	logic [shp_pkg::IMG_H_BITS-1:0]    wr_h;
	logic [shp_pkg::IMG_H_BITS-1:0]    lastr_h;
	logic                              cfg_hit;
	logic                              is_drain;
	logic                              ignore;
	logic                              go;
	logic                              emit;
	shp_pkg::cls_t                     cls;

	// Clamp written sizes, keep them as last column / last row
	assign wr_w = 32'(cfg_data[shp_pkg::IMG_W_BITS-1:0]);
	always_comb begin
		if (wr_w < 32'd3) begin
			lastc_w = 32'd2;
		end else if (wr_w > 32'(MAX_WIDTH)) begin
			lastc_w = 32'(MAX_WIDTH - 1);
		end else begin
			lastc_w = wr_w - 32'd1;
		end
	end
	assign wr_h    = cfg_data[shp_pkg::IMG_H_BITS-1:0];
	assign lastr_h = (wr_h < 16'd3) ? 16'd2 : wr_h - 16'd1;
	assign cfg_hit = cfg_we && (cfg_index == shp_pkg::REG_IMAGE_WIDTH ||
	                            cfg_index == shp_pkg::REG_IMAGE_HEIGHT);

	// Drain tick before the first slot of a frame is dropped
	assign is_drain = (item.operation == shp_pkg::OP_DRAIN);
	assign ignore   = is_drain && (in_row_q == '0) && (in_col_q == '0);
	assign go       = accept && !ignore;

	// Output trails input by one row plus one pixel
	assign emit = (in_row_q > shp_pkg::ROW_CNT_W'(1)) ||
	              ((in_row_q == shp_pkg::ROW_CNT_W'(1)) && (in_col_q != '0));

	assign cls.top     = (out_row_q == '0);
	assign cls.bottom  = (out_row_q == last_row_q);
	assign cls.left_e  = (out_col_q == '0);
	assign cls.right_e = (out_col_q == last_col_q);
	assign cls.last    = cls.bottom && cls.right_e;

	// Slot toward the line stores; a drain word fills its slot with zeros
	assign slot_valid = go;
	assign slot_col   = in_col_q;
	assign slot.emit  = emit;
	assign slot.cls   = cls;
	assign slot.data  = is_drain ? '0
	                             : {item.alpha_in, item.blue_in, item.green_in, item.red_in};

	// Size registers and position counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_col_q <= RST_LAST_COL;
			last_row_q <= RST_LAST_ROW;
			in_col_q   <= '0;
			in_row_q   <= '0;
			out_col_q  <= '0;
			out_row_q  <= '0;
		end else if (cfg_hit) begin
			if (cfg_index == shp_pkg::REG_IMAGE_WIDTH) begin
				last_col_q <= CW'(lastc_w);
			end
			if (cfg_index == shp_pkg::REG_IMAGE_HEIGHT) begin
				last_row_q <= lastr_h;
			end
			in_col_q  <= '0;
			in_row_q  <= '0;
			out_col_q <= '0;
			out_row_q <= '0;
		end else if (go) begin
			if (emit && cls.last) begin
				// frame done: next word starts a new frame
				in_col_q  <= '0;
				in_row_q  <= '0;
				out_col_q <= '0;
				out_row_q <= '0;
			end else begin
				if (in_col_q == last_col_q) begin
					in_col_q <= '0;
					in_row_q <= in_row_q + shp_pkg::ROW_CNT_W'(1);
				end else begin
					in_col_q <= in_col_q + CW'(1);
				end
				if (emit) begin
					if (cls.right_e) begin
						out_col_q <= '0;
						out_row_q <= out_row_q + shp_pkg::IMG_H_BITS'(1);
					end else begin
						out_col_q <= out_col_q + CW'(1);
					end
				end
			end
		end
	end

endmodule

>>> rtl/core/shp_lines.sv
// Two line stores and the 3x3 tap registers; builds one job per emitting slot.
// Depends on shp_pkg and shp_ram.
module shp_lines #(
	parameter int MAX_WIDTH = 2048
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          slot_valid,
	input  logic [$clog2(MAX_WIDTH)-1:0]  slot_col,
	input  shp_pkg::slot_t                slot,
	output logic                          job_valid,
	output shp_pkg::job_t                 job,
	output shp_pkg::flight_t              flight
);

	localparam int CW = $clog2(MAX_WIDTH);
	localparam int PW = $bits(shp_pkg::pixel_t);

	logic [PW-1:0]    newer_rd;
	logic [PW-1:0]    older_rd;

	logic             v_s1;
	logic [CW-1:0]    col_s1;
	shp_pkg::slot_t   slot_s1;
	logic             v_s2;
	shp_pkg::slot_t   slot_s2;
	shp_pkg::pixel_t  rgt_s2;

	shp_pkg::pixel_t  ctr_q;
	shp_pkg::pixel_t  lft_q;
	shp_pkg::pixel_t  dn_q;
	shp_pkg::pixel_t  up_q;

	// Newer row store: previous row at this column out, current pixel in
	shp_ram #(.WIDTH(PW), .DEPTH(MAX_WIDTH)) u_newer (
		.clk   (clk),
		.we    (slot_valid),
		.waddr (slot_col),
		.wdata (slot.data),
		.raddr (slot_col),
		.rdata (newer_rd)
	);

	// Older row store: fed in the following cycle from the newer store
	shp_ram #(.WIDTH(PW), .DEPTH(MAX_WIDTH)) u_older (
		.clk   (clk),
		.we    (v_s1),
		.waddr (col_s1),
		.wdata (newer_rd),
		.raddr (col_s1),
		.rdata (older_rd)
	);

	// Stage valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= slot_valid;
			v_s2 <= v_s1;
		end
	end

	// Stage payload
	always_ff @(posedge clk) begin
		col_s1  <= slot_col;
		slot_s1 <= slot;
		slot_s2 <= slot_s1;
		rgt_s2  <= shp_pkg::pixel_t'(newer_rd);
	end

	// Taps advance once per slot, in slot order
	always_ff @(posedge clk) begin
		if (v_s2) begin
			lft_q <= ctr_q;
			ctr_q <= rgt_s2;
			dn_q  <= slot_s2.data;
			up_q  <= shp_pkg::pixel_t'(older_rd);
		end
	end

	// Neighborhood of the pixel one row up and one column behind the current slot
	assign job_valid    = v_s2 && slot_s2.emit;
	assign job.center   = ctr_q;
	assign job.up       = {up_q.b, up_q.g, up_q.r};
	assign job.down     = {dn_q.b, dn_q.g, dn_q.r};
	assign job.lft      = {lft_q.b, lft_q.g, lft_q.r};
	assign job.rgt      = {rgt_s2.b, rgt_s2.g, rgt_s2.r};
	assign job.cls      = slot_s2.cls;

	assign flight.s1_emit = v_s1 && slot_s1.emit;
	assign flight.s2_emit = v_s2 && slot_s2.emit;

endmodule

>>> rtl/core/shp_queue.sv
// Short job queue between the line stores and the output stage.
// Depends on shp_pkg.
module shp_queue (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        wr_en,
	input  shp_pkg::job_t               wr_data,
	input  logic                        rd_en,
	output shp_pkg::job_t               rd_data,
	output logic                        rd_valid,
	output logic [shp_pkg::QCNT_W-1:0]  count
);

	shp_pkg::job_t                entry_q [shp_pkg::QDEPTH];
	logic [shp_pkg::QPTR_W-1:0]   wptr_q;
	logic [shp_pkg::QPTR_W-1:0]   rptr_q;
	logic [shp_pkg::QCNT_W-1:0]   count_q;

	assign rd_data  = entry_q[rptr_q];
	assign rd_valid = (count_q != '0);
	assign count    = count_q;

	// Entry storage
	always_ff @(posedge clk) begin
		if (wr_en) begin
			entry_q[wptr_q] <= wr_data;
		end
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (wr_en) begin
				wptr_q <= wptr_q + shp_pkg::QPTR_W'(1);
			end
			if (rd_en) begin
				rptr_q <= rptr_q + shp_pkg::QPTR_W'(1);
			end
			case ({wr_en, rd_en})
				2'b10:   count_q <= count_q + shp_pkg::QCNT_W'(1);
				2'b01:   count_q <= count_q - shp_pkg::QCNT_W'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

>>> rtl/core/shp_back.sv
// Back end: edge replacement, sharpen kernel, clamp and the result register.
// Depends on shp_pkg.
module shp_back (
	input  logic                clk,
	input  logic                arst_n,
	input  shp_pkg::job_t       head,
	input  logic                head_valid,
	output logic                head_take,
	output logic                empty,
	input  logic                pop,
	output shp_pkg::out_item_t  result
);

	// 5*c - u - d - l - r, clamped to 0..255
	function automatic logic [7:0] sharpen_ch(input logic [7:0] c, input logic [7:0] u,
	                                          input logic [7:0] d, input logic [7:0] l,
	                                          input logic [7:0] r);
		logic [10:0]        c5;
		logic [9:0]         s4;
		logic signed [11:0] v;
		c5 = {1'b0, c, 2'b00} + {3'b000, c};
		s4 = {2'b00, u} + {2'b00, d} + {2'b00, l} + {2'b00, r};
		v  = $signed({1'b0, c5}) - $signed({2'b00, s4});
		if (v < 12'sd0) begin
			return 8'd0;
		end else if (v > 12'sd255) begin
			return 8'd255;
		end
		return v[7:0];
	endfunction

	logic               valid_q;
	shp_pkg::out_item_t result_q;
	shp_pkg::out_item_t next_res;
	shp_pkg::rgb_t      c;
	shp_pkg::rgb_t      u;
	shp_pkg::rgb_t      d;
	shp_pkg::rgb_t      l;
	shp_pkg::rgb_t      r;
	logic               corner;

	// Missing neighbors take the center pixel
	assign c = {head.center.b, head.center.g, head.center.r};
	assign u = head.cls.top     ? c : head.up;
	assign d = head.cls.bottom  ? c : head.down;
	assign l = head.cls.left_e  ? c : head.lft;
	assign r = head.cls.right_e ? c : head.rgt;
	assign corner = (head.cls.top || head.cls.bottom) &&
	                (head.cls.left_e || head.cls.right_e);

	always_comb begin
		if (corner) begin
			next_res.red_out   = c.r;
			next_res.green_out = c.g;
			next_res.blue_out  = c.b;
		end else begin
			next_res.red_out   = sharpen_ch(c.r, u.r, d.r, l.r, r.r);
			next_res.green_out = sharpen_ch(c.g, u.g, d.g, l.g, r.g);
			next_res.blue_out  = sharpen_ch(c.b, u.b, d.b, l.b, r.b);
		end
		next_res.alpha_out = head.center.a;
		next_res.frame_end = head.cls.last;
	end

	// Result register refills while its word is taken
	assign head_take = head_valid && (!valid_q || pop);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (head_take) begin
			valid_q <= 1'b1;
		end else if (pop) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (head_take) begin
			result_q <= next_res;
		end
	end

	assign empty  = !valid_q;
	assign result = result_q;

endmodule

>>> rtl/core/sharpen_3x3_stream_filter_top.sv
// Top level of the 3x3 sharpen stream filter: front end, line stores,
// job queue and output stage. Depends on shp_pkg and all shp_* modules.
//
//  channel | handshake           | payload              | word taken when
//  --------+---------------------+----------------------+------------------
//  input   | push / full         | pixel  (in_item_t)   | push && !full
//  result  | empty / pop         | result (out_item_t)  | pop && !empty
//  config  | cfg_we              | cfg_index, cfg_data  | cfg_we
//
// One pixel or drain word per clock, sustained while full stays low; the
// limit is the single read and single write per cycle on each line store.
// A taken word passes the two line-store stages, then the job queue and the result register.
// full rises when the job queue plus the emitting words in the two
// line-store stages reach the queue depth; a stalled result never stops
// words already in flight. Reset needs no clearing pass.
module sharpen_3x3_stream_filter_top #(
	parameter int MAX_WIDTH = 2048
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            push,
	output logic                            full,
	input  shp_pkg::in_item_t               pixel,
	output logic                            empty,
	input  logic                            pop,
	output shp_pkg::out_item_t              result,
	input  logic                            cfg_we,
	input  logic [shp_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [shp_pkg::CFG_DATA_W-1:0]  cfg_data
);

	localparam int CW = $clog2(MAX_WIDTH);

	logic                         accept;
	logic                         slot_valid;
	logic [CW-1:0]                slot_col;
	shp_pkg::slot_t               slot;
	logic                         job_valid;
	shp_pkg::job_t                job;
	shp_pkg::flight_t             flight;
	shp_pkg::job_t                head;
	logic                         head_valid;
	logic                         head_take;
	logic [shp_pkg::QCNT_W-1:0]   q_count;
	logic [shp_pkg::QCNT_W-1:0]   q_claim;

	// Credit check: queue entries plus jobs still in the line stages
	assign q_claim = q_count + shp_pkg::QCNT_W'(flight.s1_emit)
	                         + shp_pkg::QCNT_W'(flight.s2_emit);
	assign full    = (q_claim >= shp_pkg::QCNT_W'(shp_pkg::QDEPTH));
	assign accept  = push && !full;

	shp_front #(.MAX_WIDTH(MAX_WIDTH)) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.accept     (accept),
		.item       (pixel),
		.slot_valid (slot_valid),
		.slot_col   (slot_col),
		.slot       (slot)
	);

	shp_lines #(.MAX_WIDTH(MAX_WIDTH)) u_lines (
		.clk        (clk),
		.arst_n     (arst_n),
		.slot_valid (slot_valid),
		.slot_col   (slot_col),
		.slot       (slot),
		.job_valid  (job_valid),
		.job        (job),
		.flight     (flight)
	);

	shp_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (job_valid),
		.wr_data  (job),
		.rd_en    (head_take),
		.rd_data  (head),
		.rd_valid (head_valid),
		.count    (q_count)
	);

	shp_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (head),
		.head_valid (head_valid),
		.head_take  (head_take),
		.empty      (empty),
		.pop        (pop),
		.result     (result)
	);

endmodule

>>> bench/tb.sv
// Self-checking bench for the 3x3 sharpen stream filter: directed cases, then random frames.
// Needs shp_pkg and sharpen_3x3_stream_filter_top; keeps its own model of the line stores.
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int MAX_W          = 2048;
	localparam int SETTLE_CYCLES  = 8;
	localparam int WATCHDOG_LIMIT = 2000;

	localparam logic [shp_pkg::CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
	localparam logic [shp_pkg::CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;

	logic                           clk = 1'b0;
	logic                           arst_n;
	logic                           push;
	logic                           full;
	shp_pkg::in_item_t              pixel;
	logic                           empty;
	logic                           pop = 1'b0;
	shp_pkg::out_item_t             result;
	logic                           cfg_we;
	logic [shp_pkg::CFG_IDX_W-1:0]  cfg_index;
	logic [shp_pkg::CFG_DATA_W-1:0] cfg_data;

	// model state: two line stores, the up tap and the frame counters
	shp_pkg::pixel_t     older_rows [MAX_W];
	shp_pkg::pixel_t     newer_rows [MAX_W];
	shp_pkg::pixel_t     up_tap_q;
	int unsigned         in_col, in_row, out_col, out_row;
	logic [11:0]         width_reg;
	logic [15:0]         height_reg;
	shp_pkg::out_item_t  sharpened_q [$];

	int send_idle_pct;
	int recv_stall_pct;
	int errors;
	int words_taken;
	int results_checked;
	int frames_done;
	int reg_writes;
	int quiet_cycles = 0;

	sharpen_3x3_stream_filter_top #(.MAX_WIDTH(MAX_W)) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.pixel     (pixel),
		.empty     (empty),
		.pop       (pop),
		.result    (result),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#10ns clk = 1'b1;
		#10ns clk = 1'b0;
	end

	// ---------------------------------------------------------------
	// Model
	// ---------------------------------------------------------------

	function automatic logic [7:0] sharpen_chan(input logic [7:0] c, u, d, l, r);
		int v;
		v = 5 * int'(c) - int'(u) - int'(d) - int'(l) - int'(r);
		if (v < 0)
			v = 0;
		else if (v > 255)
			v = 255;
		return 8'(v);
	endfunction

	task automatic frame_restart();
		in_col   = 0;
		in_row   = 0;
		out_col  = 0;
		out_row  = 0;
		up_tap_q = '0;
	endtask

	task automatic apply_register(input logic [shp_pkg::CFG_IDX_W-1:0] idx,
		input logic [shp_pkg::CFG_DATA_W-1:0] data);
		if (idx == shp_pkg::REG_IMAGE_WIDTH) begin
			width_reg = data[shp_pkg::IMG_W_BITS-1:0];
			frame_restart();
		end else if (idx == shp_pkg::REG_IMAGE_HEIGHT) begin
			height_reg = data[shp_pkg::IMG_H_BITS-1:0];
			frame_restart();
		end
	endtask

	// one accepted word: update the stores, queue the output pixel it releases
	task automatic apply_sharpen(input shp_pkg::in_item_t word);
		int unsigned         cols, rows, col, oc;
		logic                drain, emit, top, bottom, left_e, right_e, last;
		shp_pkg::pixel_t     data, up_prev, c, u, d, l, r;
		shp_pkg::out_item_t  want;
		cols = (width_reg < 3) ? 3 : (width_reg > MAX_W) ? MAX_W : width_reg;
		rows = (height_reg < 3) ? 3 : height_reg;
		drain = (word.operation == shp_pkg::OP_DRAIN);
		// drain with no frame started is dropped
		if (drain && in_row == 0 && in_col == 0)
			return;
		words_taken++;
		if (drain) begin
			data = '0;
		end else begin
			data = '{a: word.alpha_in, b: word.blue_in, g: word.green_in, r: word.red_in};
		end
		emit = (in_row > 1) || (in_row == 1 && in_col >= 1);
		up_prev = up_tap_q;
		col = in_col % MAX_W;
		up_tap_q = older_rows[col];
		older_rows[col] = newer_rows[col];
		newer_rows[col] = data;
		in_col++;
		if (in_col >= cols) begin
			in_col = 0;
			in_row++;
		end
		if (!emit)
			return;

		// neighborhood of the next output pixel, edges replicated
		oc      = out_col % MAX_W;
		c       = older_rows[oc];
		top     = (out_row == 0);
		bottom  = (out_row >= rows - 1);
		left_e  = (oc == 0);
		right_e = (oc >= cols - 1);
		u = top ? c : up_prev;
		d = bottom ? c : newer_rows[oc];
		l = left_e ? c : older_rows[(oc - 1) % MAX_W];
		r = right_e ? c : older_rows[(oc + 1) % MAX_W];
		last = bottom && right_e;
		if ((top || bottom) && (left_e || right_e)) begin
			want.red_out   = c.r;
			want.green_out = c.g;
			want.blue_out  = c.b;
		end else begin
			want.red_out   = sharpen_chan(c.r, u.r, d.r, l.r, r.r);
			want.green_out = sharpen_chan(c.g, u.g, d.g, l.g, r.g);
			want.blue_out  = sharpen_chan(c.b, u.b, d.b, l.b, r.b);
		end
		want.alpha_out = c.a;
		want.frame_end = last;
		sharpened_q.push_back(want);
		if (last) begin
			frame_restart();
		end else begin
			out_col++;
			if (out_col >= cols) begin
				out_col = 0;
				out_row++;
			end
		end
	endtask

	// ---------------------------------------------------------------
	// Result side: random stalls, compare against oldest expectation
	// ---------------------------------------------------------------

	always @(posedge clk) begin
		pop <= ($urandom_range(99) >= recv_stall_pct);
	end

	task automatic check_field(input string name, input logic [7:0] want, got);
		if (got !== want) begin
			$error("%s: expected %0d, actual %0d", name, want, got);
			errors++;
		end
	endtask

	always @(posedge clk) begin
		shp_pkg::out_item_t want;
		if (arst_n && pop && !empty) begin
			if (sharpened_q.size() == 0) begin
				$error("result word with nothing expected: %p", result);
				errors++;
			end else begin
				want = sharpened_q.pop_front();
				results_checked++;
				check_field("red_out", want.red_out, result.red_out);
				check_field("green_out", want.green_out, result.green_out);
				check_field("blue_out", want.blue_out, result.blue_out);
				check_field("alpha_out", want.alpha_out, result.alpha_out);
				check_field("frame_end", 8'(want.frame_end), 8'(result.frame_end));
				if (want.frame_end)
					frames_done++;
			end
		end
	end

	// stop a hung run: count cycles with no word moving on either side
	always @(posedge clk) begin
		if (!arst_n || cfg_we || (push && !full) || (pop && !empty)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("Verification failed");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// ---------------------------------------------------------------
	// Input side
	// ---------------------------------------------------------------

	function automatic logic [7:0] pick_chan();
		case ($urandom_range(3))
			0: return 8'h00;
			1: return 8'hFF;
			default: return 8'($urandom);
		endcase
	endfunction

	function automatic shp_pkg::in_item_t random_word();
		shp_pkg::in_item_t w;
		w.operation = 1'($urandom_range(1));
		w.red_in    = pick_chan();
		w.green_in  = pick_chan();
		w.blue_in   = pick_chan();
		w.alpha_in  = pick_chan();
		return w;
	endfunction

	task automatic send_word(input shp_pkg::in_item_t word);
		while ($urandom_range(99) < send_idle_pct) begin
			push <= 1'b0;
			@(posedge clk);
		end
		push  <= 1'b1;
		pixel <= word;
		@(posedge clk);
		while (full)
			@(posedge clk);
		apply_sharpen(word);
	endtask

	// hold input until every expected pixel is out, then let the pipe settle
	task automatic wait_idle();
		push <= 1'b0;
		@(posedge clk);
		while (sharpened_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [shp_pkg::CFG_IDX_W-1:0] idx,
		input logic [shp_pkg::CFG_DATA_W-1:0] data);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		apply_register(idx, data);
		reg_writes++;
		cfg_we <= 1'b0;
	endtask

	task automatic set_size(input logic [shp_pkg::CFG_DATA_W-1:0] w_data, h_data);
		wait_idle();
		write_reg(shp_pkg::REG_IMAGE_WIDTH, w_data);
		write_reg(shp_pkg::REG_IMAGE_HEIGHT, h_data);
	endtask

	// pixel slots then drain slots; noise flips the kind of a slot
	task automatic stream_frame(input int cols, rows, noise_pct, stop_at);
		int                slots;
		shp_pkg::in_item_t word;
		slots = cols * rows + cols + 1;
		if (stop_at >= 0 && stop_at < slots)
			slots = stop_at;
		for (int s = 0; s < slots; s++) begin
			word = random_word();
			word.operation = (s < cols * rows) ? shp_pkg::OP_PIXEL : shp_pkg::OP_DRAIN;
			if ($urandom_range(99) < noise_pct)
				word.operation = ~word.operation;
			send_word(word);
		end
	endtask

	// ---------------------------------------------------------------
	// Tests
	// ---------------------------------------------------------------

	// reset size 640 x 480: one row plus a few pixels, first outputs, then abandoned
	task automatic test_reset_size();
		shp_pkg::in_item_t word;
		for (int i = 0; i < 644; i++) begin
			word = random_word();
			word.operation = shp_pkg::OP_PIXEL;
			send_word(word);
		end
		wait_idle();
	endtask

	// 3x3 frame: stray drain up front, a drain in a pixel slot, a pixel in a drain slot
	task automatic test_edge_words();
		shp_pkg::in_item_t word;
		set_size(16'd3, 16'd3);
		word = random_word();
		word.operation = shp_pkg::OP_DRAIN;
		send_word(word);
		for (int s = 0; s < 13; s++) begin
			word.operation = (s < 9) ? shp_pkg::OP_PIXEL : shp_pkg::OP_DRAIN;
			word.red_in    = s[0] ? 8'hFF : 8'h00;
			word.green_in  = ~word.red_in;
			word.blue_in   = (s == 4) ? 8'hFF : 8'h00;
			word.alpha_in  = 8'(s * 29);
			if (s == 5)
				word.operation = shp_pkg::OP_DRAIN;
			if (s == 10)
				word.operation = shp_pkg::OP_PIXEL;
			send_word(word);
		end
	endtask

	// sizes below the floor and junk in the unused width bits; clamp extremes
	task automatic test_size_clamps();
		shp_pkg::in_item_t word;
		set_size(16'hF001, 16'h0000);
		for (int s = 0; s < 13; s++) begin
			word.operation = (s < 9) ? shp_pkg::OP_PIXEL : shp_pkg::OP_DRAIN;
			word.red_in    = (s == 4) ? 8'h00 : 8'hFF;
			word.green_in  = ~word.red_in;
			word.blue_in   = 8'h80;
			word.alpha_in  = 8'hFF;
			send_word(word);
		end
		// tallest image: never reaches the bottom, abandoned by the next write
		set_size(16'h0002, 16'hFFFF);
		stream_frame(3, 65535, 0, 12);
	endtask

	// write mid-frame drops the frame; a fresh one follows
	task automatic test_abandon_frame();
		set_size(16'd4, 16'd4);
		stream_frame(4, 4, 0, 9);
		wait_idle();
		write_reg(shp_pkg::REG_IMAGE_HEIGHT, 16'd3);
		stream_frame(4, 3, 0, -1);
	endtask

	// writes to unused indexes must leave the frame running
	task automatic test_spare_index();
		shp_pkg::in_item_t word;
		set_size(16'd5, 16'd4);
		for (int s = 0; s < 26; s++) begin
			if (s == 12) begin
				wait_idle();
				write_reg(REG_SPARE_2, 16'hFFFF);
				write_reg(REG_SPARE_3, 16'hFFFF);
			end
			word = random_word();
			word.operation = (s < 20) ? shp_pkg::OP_PIXEL : shp_pkg::OP_DRAIN;
			send_word(word);
		end
	endtask

	// width above the store size clamps to the full store: no word may
	// come out before a whole row has gone in
	task automatic test_widest_rows();
		set_size(16'h0FFF, 16'd3);
		stream_frame(MAX_W, 3, 0, 12);
	endtask

	task automatic run_random_frames(input int idle_pct, stall_pct, word_goal);
		int   start, raw_w, raw_h, cols, rows, noise, stop;
		logic need_size;
		send_idle_pct  = idle_pct;
		recv_stall_pct = stall_pct;
		start = words_taken;
		need_size = 1'b1;
		while (words_taken - start < word_goal) begin
			if (need_size || $urandom_range(2) == 0) begin
				raw_w = ($urandom_range(7) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 12);
				raw_h = ($urandom_range(7) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 6);
				cols = (raw_w < 3) ? 3 : raw_w;
				rows = (raw_h < 3) ? 3 : raw_h;
				set_size({4'($urandom), 12'(raw_w)}, 16'(raw_h));
			end
			need_size = 1'b0;
			noise = ($urandom_range(3) == 0) ? 5 : 0;
			stop = -1;
			if ($urandom_range(7) == 0) begin
				stop = $urandom_range(1, cols * rows);
				need_size = 1'b1;
			end
			stream_frame(cols, rows, noise, stop);
			// a flipped slot shifts the frame; restart it cleanly
			if (noise != 0)
				need_size = 1'b1;
		end
	endtask

	initial begin
		arst_n    <= 1'b0;
		push      <= 1'b0;
		pixel     <= '0;
		cfg_we    <= 1'b0;
		cfg_index <= '0;
		cfg_data  <= '0;
		send_idle_pct   = 0;
		recv_stall_pct  = 0;
		errors          = 0;
		words_taken     = 0;
		results_checked = 0;
		frames_done     = 0;
		reg_writes      = 0;
		foreach (older_rows[i]) begin
			older_rows[i] = '0;
			newer_rows[i] = '0;
		end
		width_reg  = 12'(shp_pkg::RESET_WIDTH);
		height_reg = 16'(shp_pkg::RESET_HEIGHT);
		frame_restart();
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_size();
		test_edge_words();
		test_size_clamps();
		test_abandon_frame();
		test_spare_index();
		test_widest_rows();
		run_random_frames(0, 0, 20);
		run_random_frames(51, 0, 20);
		run_random_frames(0, 51, 20);
		run_random_frames(21, 21, 20);

		push <= 1'b0;
		while (sharpened_q.size() != 0)
			@(posedge clk);
		repeat (2 * SETTLE_CYCLES) @(posedge clk);

		$display("Run: %0d words into the filter, %0d pixels checked, %0d frames closed",
			words_taken, results_checked, frames_done);
		$display("     %0d register writes, full frames up to 12 x 6, partial rows at wide sizes",
			reg_writes);
		if (errors == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule

>>> filelist.f
rtl/core/shp_pkg.sv
rtl/core/shp_ram.sv
rtl/core/shp_front.sv
rtl/core/shp_lines.sv
rtl/core/shp_queue.sv
rtl/core/shp_back.sv
rtl/core/sharpen_3x3_stream_filter_top.sv
bench/tb.sv
